FILE: hw/rtl/ssmooth_pkg.sv
// Shared types, constants and helpers of the separable smoothing filter.
`default_nettype none
package ssmooth_pkg;
  localparam int MaxTaps   = 8;
  localparam int MaxWidth  = 1024;
  localparam int PixBits   = 16;
  localparam int HsumBits  = PixBits + 2;
  localparam int WinLen    = 2 * MaxTaps - 1;
  localparam int LsRows    = 2 * MaxTaps - 2;
  localparam int ColBits   = 10;
  localparam int RowBits   = 16;
  localparam int SlotBits  = 4;
  localparam int LsDepth   = LsRows * MaxWidth;
  localparam int LsAddrW   = SlotBits + ColBits;
  localparam int TermBits  = 4;
  localparam int TapIdxW   = 3;
  localparam int CoefBits  = 16;
  localparam int ProdBits  = HsumBits + CoefBits;
  localparam int AccBits   = ProdBits + 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegLineWidth = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFrameRows = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTapCount  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoefLow   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCoefHigh  = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_HTERM, ST_HDRAIN, ST_HSUM, ST_VTERM, ST_VDRAIN, ST_OUTW
  } state_t;

  typedef struct packed {
    logic clear;       // write zero at the clear pointer
    logic take;        // accept input word, latch position flags
    logic term_start;  // restart term counter and accumulator
    logic issue;       // issue one multiply term
    logic vert;        // terms come from the line store
    logic hs_load;     // finish horizontal sum, write line store
    logic out_load;    // finish vertical sum into output register
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic do_h_now;
    logic emit;
    logic term_last;
    logic busy;
    logic out_free;
  } stat_t;

  // (acc + half) >> 15, saturated to an all-ones limit of PixBits bits when narrow, else HsumBits bits
  function automatic logic [HsumBits-1:0] round_sat(input logic [AccBits-1:0] acc,
                                                    input logic            narrow);
    logic [AccBits:0]   sum;
    logic [AccBits-15:0] v;
    logic [HsumBits-1:0] res;
    sum = {1'b0, acc} + (AccBits+1)'(16384);
    v   = sum[AccBits:15];
    if (narrow) begin
      res = (v > (AccBits-14)'(2**PixBits - 1)) ? HsumBits'(2**PixBits - 1) : v[HsumBits-1:0];
    end else begin
      res = (v > (AccBits-14)'(2**HsumBits - 1)) ? HsumBits'(2**HsumBits - 1)
                                                  : v[HsumBits-1:0];
    end
    return res;
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/separable_symmetric_smoothing.sv
// Top level of the separable symmetric 2-D smoothing filter.
//  channel   dir  handshake            contents
//  s_axis    in   tvalid/tready        tdata[15:0] pixel_in
//  m_axis    out  tvalid/tready        tdata[15:0] pixel_out, [31:16] out_row,
//                                      [41:32] out_col; tlast frame_last
//  cfg       in   cfg_we               cfg_index, cfg_data
// One word at a time. A border pixel before the horizontal span is only taken in;
// otherwise 2K-1 horizontal taps go through the single multiplier, the pipe
// drains and the sum is rounded. An interior pixel then adds 2K-1 vertical terms
// (the new sum and 2K-2 line store reads), a drain and a load of the output register.
// After reset a clear pass zeroes all 14336 words of the line store; s_axis_tready
// stays low through it. A stalled result holds the block in its output wait.
`default_nettype none
module separable_symmetric_smoothing (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // pixel_in
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [47:0] m_axis_tdata,   // pixel_out, out_row, out_col, zero fill
  output      logic        m_axis_tlast,   // frame_last
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import ssmooth_pkg::*;

  cmd_t               cmd;
  stat_t              st;
  logic [PixBits-1:0] pix_out;
  logic [RowBits-1:0] row_out;
  logic [ColBits-1:0] col_out;

  ssmooth_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ssmooth_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (s_axis_tdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .pix_out   (pix_out),
    .row_out   (row_out),
    .col_out   (col_out),
    .last_out  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, col_out, row_out, pix_out};
endmodule
`default_nettype wire

FILE: hw/rtl/ssmooth_ctrl.sv
// Sequencer of the smoothing filter: clear pass, term loops, output hand-off.
`default_nettype none
module ssmooth_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire ssmooth_pkg::stat_t st,
  output      ssmooth_pkg::cmd_t  cmd
);
  import ssmooth_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take       = 1'b1;
          cmd.term_start = 1'b1;
          if (st.do_h_now) state_next = ST_HTERM;
        end
      end
      ST_HTERM: begin
        cmd.issue = 1'b1;
        if (st.term_last) state_next = ST_HDRAIN;
      end
      ST_HDRAIN: begin
        if (!st.busy) state_next = ST_HSUM;
      end
      ST_HSUM: begin
        cmd.hs_load    = 1'b1;
        cmd.term_start = 1'b1;
        state_next     = st.emit ? ST_VTERM : ST_IDLE;
      end
      ST_VTERM: begin
        cmd.issue = 1'b1;
        cmd.vert  = 1'b1;
        if (st.term_last) state_next = ST_VDRAIN;
      end
      ST_VDRAIN: begin
        cmd.vert = 1'b1;
        if (!st.busy) state_next = ST_OUTW;
      end
      ST_OUTW: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/ssmooth_dp.sv
// Datapath: config, position, pixel window, line store, MAC pipe, output register.
`default_nettype none
module ssmooth_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [ssmooth_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [ssmooth_pkg::CfgDataW-1:0]    cfg_data,
  input  wire logic [ssmooth_pkg::PixBits-1:0]     pix_in,
  input  wire ssmooth_pkg::cmd_t                   cmd,
  output      ssmooth_pkg::stat_t                  st,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic [ssmooth_pkg::PixBits-1:0]     pix_out,
  output      logic [ssmooth_pkg::RowBits-1:0]     row_out,
  output      logic [ssmooth_pkg::ColBits-1:0]     col_out,
  output      logic                                last_out
);
  import ssmooth_pkg::*;

  // configuration registers
  logic [10:0]          line_width;
  logic [15:0]          frame_rows;
  logic [3:0]           tap_count;
  logic [2*CfgDataW-1:0] coefs;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 11'd1024;
      frame_rows <= 16'd480;
      tap_count  <= 4'd3;
      coefs      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegLineWidth: line_width <= cfg_data[10:0];
        RegFrameRows: frame_rows <= cfg_data[15:0];
        RegTapCount:  tap_count  <= cfg_data[3:0];
        RegCoefLow:   coefs[CfgDataW-1:0] <= cfg_data;
        RegCoefHigh:  coefs[2*CfgDataW-1:CfgDataW] <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [10:0]         width;
  logic [15:0]         rows;
  logic [3:0]          k;
  logic [TapIdxW-1:0]  km1;
  logic [TermBits-1:0] span;
  always_comb begin
    width = (line_width == 11'd0) ? 11'd1 :
            (line_width > 11'(MaxWidth)) ? 11'(MaxWidth) : line_width;
    rows  = (frame_rows == 16'd0) ? 16'd1 : frame_rows;
    k     = (tap_count == 4'd0) ? 4'd1 : (tap_count > 4'(MaxTaps)) ? 4'(MaxTaps) : tap_count;
    km1   = TapIdxW'(k - 4'd1);
    span  = TermBits'({km1, 1'b0});
  end

  // raster position, line store slot = row mod LsRows
  logic [ColBits-1:0]  col_pos;
  logic [RowBits-1:0]  row_pos;
  logic [SlotBits-1:0] slot_pos;
  logic [ColBits:0]    col_inc;
  logic [RowBits:0]    row_inc;
  assign col_inc = {1'b0, col_pos} + 11'd1;
  assign row_inc = {1'b0, row_pos} + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos  <= '0;
      row_pos  <= '0;
      slot_pos <= '0;
    end else if (cmd.take) begin
      if (col_inc >= width) begin
        col_pos <= '0;
        if (row_inc >= {1'b0, rows}) begin
          row_pos  <= '0;
          slot_pos <= '0;
        end else begin
          row_pos  <= row_inc[RowBits-1:0];
          slot_pos <= (slot_pos == SlotBits'(LsRows - 1)) ? '0 : slot_pos + 4'd1;
        end
      end else begin
        col_pos <= col_inc[ColBits-1:0];
      end
    end
  end

  // flags latched with the word
  logic                do_h_now, emit_now, last_now;
  logic                emit;
  logic [ColBits-1:0]  oc;
  logic [RowBits-1:0]  orow;
  logic                olast;
  logic [SlotBits-1:0] cur_slot;
  assign do_h_now = ({1'b0, col_pos} >= 11'(span));
  assign emit_now = do_h_now && (row_pos >= 16'(span)) && (row_pos < rows)
                    && ({1'b0, col_pos} < width);
  assign last_now = (row_inc == {1'b0, rows}) && (col_inc == width);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      emit     <= emit_now;
      oc       <= col_pos - ColBits'(km1);
      orow     <= row_pos - RowBits'(km1);
      olast    <= last_now;
      cur_slot <= slot_pos;
    end
  end

  // pixel window, newest first
  logic [PixBits-1:0] win [WinLen];
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      win[0] <= pix_in;
      for (int i = 1; i < WinLen; i++) win[i] <= win[i-1];
    end
  end

  // term counter
  logic [TermBits-1:0] term;
  always_ff @(posedge clk) begin
    if (cmd.term_start)  term <= '0;
    else if (cmd.issue)  term <= term + 4'd1;
  end

  // tap weight of the current term: |term - (K-1)|
  logic [TapIdxW-1:0]  tap_idx;
  logic [CoefBits-1:0] weight;
  logic [SlotBits-1:0] rd_slot;
  logic [TermBits-1:0] term_k;
  always_comb begin
    term_k  = TermBits'(km1);
    tap_idx = (term >= term_k) ? TapIdxW'(term - term_k) : TapIdxW'(term_k - term);
    weight  = coefs[tap_idx*CoefBits +: CoefBits];
    rd_slot = (cur_slot >= term) ? SlotBits'(cur_slot - term)
                                 : SlotBits'(cur_slot + SlotBits'(LsRows) - term);
  end

  // clear pointer for the pass after reset
  logic [LsAddrW-1:0] clr_addr;
  always_ff @(posedge clk) begin
    if (rst)            clr_addr <= '0;
    else if (cmd.clear) clr_addr <= clr_addr + 14'd1;
  end

  // horizontal sum register
  logic [AccBits-1:0]  acc;
  logic [HsumBits-1:0] hs_new, hs;
  logic [HsumBits-1:0] pv_new;
  assign hs_new = round_sat(acc, 1'b0);
  assign pv_new = round_sat(acc, 1'b1);
  always_ff @(posedge clk) begin
    if (cmd.hs_load) hs <= hs_new;
  end

  // line store, one write and one registered read a cycle;
  // an interior pixel writes its sum only after the vertical reads, since
  // with the widest kernel the oldest row read shares the slot of the new one
  logic [HsumBits-1:0] ls_mem [LsDepth];
  logic [HsumBits-1:0] ls_rdata;
  logic                ls_we;
  logic [LsAddrW-1:0]  ls_waddr;
  logic [HsumBits-1:0] ls_wdata;
  assign ls_we    = cmd.clear || (cmd.hs_load && !emit) || cmd.out_load;
  assign ls_waddr = cmd.clear ? clr_addr : {cur_slot, oc};
  assign ls_wdata = cmd.clear ? '0 : (cmd.hs_load ? hs_new : hs);
  always_ff @(posedge clk) begin
    if (ls_we) ls_mem[ls_waddr] <= ls_wdata;
  end
  always_ff @(posedge clk) begin
    ls_rdata <= ls_mem[{rd_slot, oc}];
  end

  // MAC pipe: operand select, multiply, accumulate
  logic                v1, v2, mem_sel1;
  logic [HsumBits-1:0] opnd1;
  logic [CoefBits-1:0] w1;
  logic [ProdBits-1:0] prod;
  logic [HsumBits-1:0] opnd;
  assign opnd = mem_sel1 ? ls_rdata : opnd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    mem_sel1 <= cmd.vert && (term != '0);
    opnd1    <= cmd.vert ? hs : HsumBits'(win[term]);
    w1       <= weight;
    prod     <= opnd * w1;
    if (cmd.term_start) acc <= '0;
    else if (v2)        acc <= acc + AccBits'(prod);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pix_out  <= pv_new[PixBits-1:0];
      row_out  <= orow;
      col_out  <= oc;
      last_out <= olast;
    end
  end

  // status
  always_comb begin
    st.clear_done = (clr_addr == LsAddrW'(LsDepth - 1));
    st.do_h_now   = do_h_now;
    st.emit       = emit;
    st.term_last  = (term == span);
    st.busy       = v1 || v2;
    st.out_free   = !out_valid || out_ready;
  end
endmodule
`default_nettype wire

FILE: hw/rtl/ssmooth_checker.sv
// Port-level checks of the smoothing filter, bound to the top level.
`default_nettype none
module ssmooth_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output word changed under stall");

  // no input taken just after a reset, at the start of the line store clear pass
  a_clear_block: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("ready during clear pass");

  // a result is loaded only while input is held off
  a_out_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while accepting input");

  // zero fill bits of tdata stay zero
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[47:42] == 6'd0)
    else $error("tdata fill bits set");
endmodule

bind separable_symmetric_smoothing ssmooth_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
